FILE: rtl/httd_pkg.sv
// ----------------------------------------------------------------------------
// httd_pkg
// Shared constants and types for the table-driven Huffman tree decoder.
// ----------------------------------------------------------------------------
package httd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 16;
    localparam int COUNT_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int BITCNT_W    = $clog2(BYTE_W + 1);
    localparam int MEM_W       = ENTRY_W + 1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [IDX_W-1:0]   addr;
        logic [MEM_W-1:0]   wdata;
    } t_mem_req;

    typedef struct packed {
        logic [ENTRY_W-1:0] symbol;
        logic               last_of_byte;
        logic               run_done;
    } t_sym;

endpackage

FILE: rtl/httd_table.sv
// ----------------------------------------------------------------------------
// httd_table
// Single-port tree table: entry value plus leaf flag, registered read.
// ----------------------------------------------------------------------------
module httd_table (
    input  logic                   i_clk,
    input  httd_pkg::t_mem_req     i_req,
    output logic [httd_pkg::MEM_W-1:0] o_rdata
);
    import httd_pkg::*;

    logic [MEM_W-1:0] r_mem [TABLE_DEPTH];
    logic [MEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/httd_out.sv
// ----------------------------------------------------------------------------
// httd_out
// Output register stage for decoded symbol words.
// ----------------------------------------------------------------------------
module httd_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  httd_pkg::t_sym              i_sym,
    output logic                        o_slot_free,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [httd_pkg::ENTRY_W-1:0] o_symbol,
    output logic                        o_last_of_byte,
    output logic                        o_run_done
);
    import httd_pkg::*;

    logic r_valid;
    t_sym r_sym;

    assign o_slot_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_sym <= i_sym;
        end
    end

    assign o_valid        = r_valid;
    assign o_symbol       = r_sym.symbol;
    assign o_last_of_byte = r_sym.last_of_byte;
    assign o_run_done     = r_sym.run_done;

endmodule

FILE: rtl/httd_walk.sv
// ----------------------------------------------------------------------------
// httd_walk
// Tree walk sequencer: one table read per coded bit, leaf symbols held one
// deep so the final symbol of a byte can be marked.
// ----------------------------------------------------------------------------
module httd_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [httd_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [httd_pkg::ENTRY_W-1:0]  i_entry_value,
    input  logic                          i_entry_is_leaf,
    input  logic                          i_start_run,
    input  logic [httd_pkg::COUNT_W-1:0]  i_symbol_count,
    input  logic [httd_pkg::BYTE_W-1:0]   i_data_byte,
    output httd_pkg::t_mem_req            o_mem_req,
    input  logic [httd_pkg::MEM_W-1:0]    i_mem_rdata,
    input  logic                          i_slot_free,
    output logic                          o_push,
    output httd_pkg::t_sym                o_sym
);
    import httd_pkg::*;

    t_state r_state, n_state;

    logic [IDX_W-1:0]    r_node, n_node;
    logic [ENTRY_W-1:0]  r_cur, n_cur;
    logic [ENTRY_W-1:0]  r_root;
    logic [COUNT_W-1:0]  r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_next, n_next;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [BITCNT_W-1:0] r_bits, n_bits;
    logic                r_hold_v, n_hold_v;
    logic [ENTRY_W-1:0]  r_hold_sym, n_hold_sym;
    logic                r_hold_done, n_hold_done;

    logic                accept;
    logic                leaf_now;
    logic [ENTRY_W-1:0]  rd_value;
    logic                advance;
    logic                issue;
    logic [IDX_W-1:0]    eff_node;
    logic [ENTRY_W-1:0]  eff_cur;
    logic [COUNT_W-1:0]  eff_cnt;
    logic [IDX_W-1:0]    rd_addr;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign rd_value = i_mem_rdata[ENTRY_W-1:0];
    assign leaf_now = r_pend && i_mem_rdata[ENTRY_W];
    assign advance  = !leaf_now || !r_hold_v || i_slot_free;

    assign eff_node = leaf_now ? '0 : (r_pend ? r_next : r_node);
    assign eff_cur  = leaf_now ? r_root : (r_pend ? rd_value : r_cur);
    assign eff_cnt  = leaf_now ? r_cnt - COUNT_W'(1) : r_cnt;
    assign issue    = advance && (r_bits != '0) && (eff_cnt != '0);
    assign rd_addr  = eff_node + eff_cur[IDX_W-1:0] + IDX_W'(r_byte[BYTE_W-1]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_action == ACT_DECODE) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance && !issue) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_v || i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_node      = r_node;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_next      = r_next;
        n_byte      = r_byte;
        n_bits      = r_bits;
        n_hold_v    = r_hold_v;
        n_hold_sym  = r_hold_sym;
        n_hold_done = r_hold_done;
        o_mem_req   = '0;
        o_push      = 1'b0;
        o_sym       = '{symbol: r_hold_sym, last_of_byte: 1'b0, run_done: r_hold_done};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_LOAD) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.addr  = i_entry_index;
                        o_mem_req.wdata = {i_entry_is_leaf, i_entry_value};
                        if (i_entry_index == r_node) begin
                            n_cur = i_entry_value;
                        end
                    end else begin
                        n_byte = i_data_byte;
                        n_bits = BITCNT_W'(BYTE_W);
                        n_pend = 1'b0;
                        if (i_start_run) begin
                            n_node = '0;
                            n_cur  = r_root;
                            n_cnt  = i_symbol_count;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (advance) begin
                    n_node = eff_node;
                    n_cur  = eff_cur;
                    n_cnt  = eff_cnt;
                    n_pend = issue;
                    if (leaf_now) begin
                        o_push      = r_hold_v;
                        n_hold_v    = 1'b1;
                        n_hold_sym  = rd_value;
                        n_hold_done = (r_cnt == COUNT_W'(1));
                    end
                    if (issue) begin
                        o_mem_req.re   = 1'b1;
                        o_mem_req.addr = rd_addr;
                        n_next = rd_addr;
                        n_byte = {r_byte[BYTE_W-2:0], 1'b0};
                        n_bits = r_bits - BITCNT_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                o_sym.last_of_byte = 1'b1;
                if (r_hold_v && i_slot_free) begin
                    o_push   = 1'b1;
                    n_hold_v = 1'b0;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_node   <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_node   <= n_node;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_next      <= n_next;
        r_byte      <= n_byte;
        r_bits      <= n_bits;
        r_hold_sym  <= n_hold_sym;
        r_hold_done <= n_hold_done;
        if (accept && i_action == ACT_LOAD && i_entry_index == '0) begin
            r_root <= i_entry_value;
        end
    end

endmodule

FILE: rtl/huffman_tree_table_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_table_decoder_top
// Huffman decoder walking a code tree held in a 1024-entry table.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries one word per item. A load word
// (action 0) writes one table entry. A decode word (action 1) feeds one
// data byte, MSB first; start_run returns the walk to the root and takes a
// new symbol count.
// Each coded bit costs one read of the single-port table, so a decode byte
// occupies the block while it is accepted, while the eight dependent reads
// and the last lookup run, and while the final symbol is released.
// It ends earlier once the symbol count runs out.
// Output channel (o_valid / i_stall) carries one word per decoded symbol.
// A symbol is held until the next leaf or the end of its byte, so that the
// byte's final symbol carries last_of_byte.
// A stalled receiver holds the output word; the walk pauses when it has a
// symbol to pass on and no room for it, and o_stall stays high meanwhile.
// Reset returns the walk to the root with a zero count; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module huffman_tree_table_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [9:0]  i_entry_index,
    input  logic [15:0] i_entry_value,
    input  logic        i_entry_is_leaf,
    input  logic        i_start_run,
    input  logic [15:0] i_symbol_count,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_symbol,
    output logic        o_last_of_byte,
    output logic        o_run_done
);
    import httd_pkg::*;

    t_mem_req         mem_req;
    logic [MEM_W-1:0] mem_rdata;
    logic             slot_free;
    logic             push;
    t_sym             sym;

    httd_table u_table (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    httd_walk u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_entry_is_leaf (i_entry_is_leaf),
        .i_start_run     (i_start_run),
        .i_symbol_count  (i_symbol_count),
        .i_data_byte     (i_data_byte),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata),
        .i_slot_free     (slot_free),
        .o_push          (push),
        .o_sym           (sym)
    );

    httd_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_sym          (sym),
        .o_slot_free    (slot_free),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_last_of_byte (o_last_of_byte),
        .o_run_done     (o_run_done)
    );

endmodule

FILE: tb/huffman_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_decode_checker
// Watches both channels of the tree decoder, predicts every decoded symbol
// from a private copy of the code table and compares the output words.
// ----------------------------------------------------------------------------
module huffman_decode_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_action,
    input  logic [httd_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [httd_pkg::ENTRY_W-1:0]  i_entry_value,
    input  logic                          i_entry_is_leaf,
    input  logic                          i_start_run,
    input  logic [httd_pkg::COUNT_W-1:0]  i_symbol_count,
    input  logic [httd_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [httd_pkg::ENTRY_W-1:0]  i_symbol,
    input  logic                          i_last_of_byte,
    input  logic                          i_run_done,
    output int                            o_fail_count,
    output int                            o_pending
);
    import httd_pkg::*;

    logic [ENTRY_W-1:0] tree_value [TABLE_DEPTH];
    logic               tree_leaf  [TABLE_DEPTH];
    logic [IDX_W-1:0]   walk_node;
    logic [COUNT_W-1:0] left_cnt;
    t_sym               pending_symbols [$];
    t_sym               seen_sym;
    t_sym               want_sym;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic walk_byte(input logic start, input logic [COUNT_W-1:0] cnt,
                             input logic [BYTE_W-1:0] data);
        t_sym byte_syms [BYTE_W];
        int   n_out;
        n_out = 0;
        if (start) begin
            walk_node = '0;
            left_cnt  = cnt;
        end
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            if (left_cnt == 0) break;
            walk_node = walk_node + tree_value[walk_node][IDX_W-1:0] + IDX_W'(data[b]);
            if (tree_leaf[walk_node]) begin
                left_cnt = left_cnt - COUNT_W'(1);
                byte_syms[n_out].symbol       = tree_value[walk_node];
                byte_syms[n_out].last_of_byte = 1'b0;
                byte_syms[n_out].run_done     = (left_cnt == 0);
                n_out++;
                walk_node = '0;
            end
        end
        if (n_out > 0) byte_syms[n_out-1].last_of_byte = 1'b1;
        for (int k = 0; k < n_out; k++) pending_symbols.push_back(byte_syms[k]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            walk_node = '0;
            left_cnt  = '0;
            pending_symbols.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_LOAD) begin
                    tree_value[i_entry_index] = i_entry_value;
                    tree_leaf[i_entry_index]  = i_entry_is_leaf;
                end else begin
                    walk_byte(i_start_run, i_symbol_count, i_data_byte);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                seen_sym.symbol       = i_symbol;
                seen_sym.last_of_byte = i_last_of_byte;
                seen_sym.run_done     = i_run_done;
                if (pending_symbols.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected word: symbol %h last %b done %b",
                                 i_symbol, i_last_of_byte, i_run_done);
                end else begin
                    want_sym = pending_symbols.pop_front();
                    if (seen_sym != want_sym) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: symbol %h/%h last %b/%b done %b/%b (exp/got)",
                                     want_sym.symbol, seen_sym.symbol,
                                     want_sym.last_of_byte, seen_sym.last_of_byte,
                                     want_sym.run_done, seen_sym.run_done);
                    end
                end
            end
        end
        o_pending = pending_symbols.size();
    end

endmodule

FILE: tb/huffman_tree_table_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_table_decoder_top_test
// Runs directed decodes over a hand-built tree, then random trees and runs
// with random idling on both channels.
// ----------------------------------------------------------------------------
module huffman_tree_table_decoder_top_test;
    import httd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_DECODES = 200;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_INNER    = 12;
    localparam int MAX_DEPTH    = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = ACT_LOAD;
    logic [9:0]  i_entry_index = '0;
    logic [15:0] i_entry_value = '0;
    logic        i_entry_is_leaf = 1'b0;
    logic        i_start_run = 1'b0;
    logic [15:0] i_symbol_count = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_symbol;
    logic        o_last_of_byte;
    logic        o_run_done;

    logic        quiet = 1'b0;
    int          cycles = 0;
    int          fail_count;
    int          pending;
    int          rand_decodes;
    int          phase;
    int          pick;
    int          n_bytes;
    logic [15:0] run_len;
    int          leaf_q [$];

    huffman_tree_table_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_entry_is_leaf (i_entry_is_leaf),
        .i_start_run     (i_start_run),
        .i_symbol_count  (i_symbol_count),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_symbol        (o_symbol),
        .o_last_of_byte  (o_last_of_byte),
        .o_run_done      (o_run_done)
    );

    huffman_decode_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_entry_is_leaf (i_entry_is_leaf),
        .i_start_run     (i_start_run),
        .i_symbol_count  (i_symbol_count),
        .i_data_byte     (i_data_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_symbol        (o_symbol),
        .i_last_of_byte  (o_last_of_byte),
        .i_run_done      (o_run_done),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) i_stall = !quiet && ($urandom_range(0, 99) < 17);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_word(input logic act, input logic [9:0] idx, input logic [15:0] val,
                             input logic leaf, input logic start, input logic [15:0] cnt,
                             input logic [7:0] data);
        while (!quiet && $urandom_range(0, 99) < 17) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_action        = act;
        i_entry_index   = idx;
        i_entry_value   = val;
        i_entry_is_leaf = leaf;
        i_start_run     = start;
        i_symbol_count  = cnt;
        i_data_byte     = data;
        i_valid         = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_entry(input logic [9:0] idx, input logic [15:0] val, input logic leaf);
        push_word(ACT_LOAD, idx, val, leaf, 1'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic decode_byte(input logic start, input logic [15:0] cnt, input logic [7:0] data);
        push_word(ACT_DECODE, 10'($urandom), 16'($urandom), 1'($urandom), start, cnt, data);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // complete tree rooted at 0; children of a node sit in an even-aligned pair
    task automatic grow_tree();
        int          node_q [$];
        int          depth_q [$];
        int          slot;
        int          node;
        int          depth;
        int          inner;
        int          child;
        logic [15:0] offs;
        leaf_q.delete();
        slot  = 2 * $urandom_range(1, 511);
        inner = 1;
        node_q.push_back(0);
        depth_q.push_back(0);
        while (node_q.size() > 0) begin
            node  = node_q.pop_front();
            depth = depth_q.pop_front();
            offs  = 16'((slot - node) & (TABLE_DEPTH - 1))
                  + 16'(TABLE_DEPTH * $urandom_range(0, 63));
            load_entry(10'(node), offs, node == 0 ? 1'($urandom) : 1'b0);
            for (int c = 0; c < 2; c++) begin
                child = slot + c;
                if (depth >= MAX_DEPTH || inner >= MAX_INNER || $urandom_range(0, 99) < 45) begin
                    load_entry(10'(child), 16'($urandom), 1'b1);
                    leaf_q.push_back(child);
                end else begin
                    node_q.push_back(child);
                    depth_q.push_back(depth + 1);
                    inner++;
                end
            end
            slot = (slot + 2) % TABLE_DEPTH;
            if (slot == 0) slot = 2;
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // codes: 0 -> ffff, 10 -> 0000, 110 -> 1234, 111 -> 8000
        load_entry(10'd0,    16'h0001, 1'b1);   // root flagged leaf, still walked
        load_entry(10'd1,    16'hFFFF, 1'b1);
        load_entry(10'd2,    16'd1020, 1'b0);
        load_entry(10'd1022, 16'h0000, 1'b1);
        load_entry(10'd1023, 16'hFC05, 1'b0);   // wraps past the table end
        load_entry(10'd4,    16'h1234, 1'b1);
        load_entry(10'd5,    16'h8000, 1'b1);
        decode_byte(1'b0, 16'h1234, 8'h00);     // no run yet
        decode_byte(1'b1, 16'h0000, 8'hFF);     // zero count
        decode_byte(1'b1, 16'd8,    8'h00);     // eight symbols from one word
        decode_byte(1'b0, 16'hFFFF, 8'hFF);     // run already done
        decode_byte(1'b1, 16'hFFFF, 8'hFF);     // code left open across words
        load_entry(10'd6, 16'($urandom), 1'b1);
        decode_byte(1'b0, 16'd0,    8'h00);
        decode_byte(1'b1, 16'd3,    8'hAA);     // count runs out mid word
        decode_byte(1'b1, 16'd2,    8'hC0);
        decode_byte(1'b1, 16'd1,    8'h7F);
        wait_drained();

        rand_decodes = 0;
        phase        = 0;
        while (rand_decodes < RAND_DECODES) begin
            if (phase % 4 == 0) grow_tree();
            pick = $urandom_range(0, 19);
            if (pick == 0)      run_len = 16'h0000;
            else if (pick == 1) run_len = 16'hFFFF;
            else if (pick == 2) run_len = 16'($urandom);
            else                run_len = 16'($urandom_range(1, 24));
            n_bytes = $urandom_range(1, 10);
            for (int k = 0; k < n_bytes; k++) begin
                // relabel a leaf of the current tree with a new symbol
                if (leaf_q.size() > 0 && $urandom_range(0, 99) < 8)
                    load_entry(10'(leaf_q[$urandom_range(0, leaf_q.size() - 1)]),
                               16'($urandom), 1'b1);
                decode_byte(k == 0 || $urandom_range(0, 99) < 5,
                            k == 0 ? run_len : 16'($urandom), 8'($urandom));
                rand_decodes++;
                quiet = rand_decodes >= 70 && rand_decodes < 130;
            end
            if (phase % 6 == 5) wait_drained();
            phase++;
        end

        quiet = 1'b0;
        wait_drained();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
